>>> hdl/roa_pkg.sv
`timescale 1ns / 1ps

package roa_pkg;

   localparam int GRID_SIZE_DEFAULT = 256;
   localparam int COORD_WIDTH = 9;
   localparam int AREA_WIDTH = 17;
   localparam logic [AREA_WIDTH-1:0] AREA_MAX = '1;

   typedef struct packed {
      logic                   kind;
      logic [COORD_WIDTH-1:0] left_x;
      logic [COORD_WIDTH-1:0] bottom_y;
      logic [COORD_WIDTH-1:0] right_x;
      logic [COORD_WIDTH-1:0] top_y;
   } req_type;

   typedef struct packed {
      logic                  accepted;
      logic [AREA_WIDTH-1:0] total_area;
   } rsp_type;

endpackage

>>> hdl/roa_row_mem.sv
`timescale 1ns / 1ps

module roa_row_mem #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 256,
   parameter int ADDR_WIDTH = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

>>> hdl/rectangle_occupancy_allocator_core.sv
`timescale 1ns / 1ps

// Rectangle occupancy allocator over a GRID_SIZE x GRID_SIZE cell bitmap.
// Input channel req_*: one transfer is a clear (kind 0) or a place request
// for the half-open rectangle [left_x,right_x) x [bottom_y,top_y); any
// coordinate above GRID_SIZE is saturated to GRID_SIZE.
// Result channel rsp_*: exactly one transfer per request, in order, with the
// accepted flag and the covered area since the last clear.
// The bitmap is a memory of GRID_SIZE rows of GRID_SIZE bits, one row per
// column x, with one read and one write port. A place request scans its
// rows once to check them and once more to mark them, one row per cycle
// through the read port; a conflict stops the check early. A degenerate
// rectangle skips the scan and is accepted. A clear writes zero to every row.
// One request is worked on at a time; req_stall is high while it runs.
// A finished result waits in the output register while rsp_stall is high;
// the next request is already taken meanwhile and holds before its result.
// Reset starts a clearing pass during which no request is taken.

module rectangle_occupancy_allocator_core #(
   parameter int GRID_SIZE = roa_pkg::GRID_SIZE_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  roa_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output roa_pkg::rsp_type rsp_payload
);

   import roa_pkg::*;

   localparam int CW = $clog2(GRID_SIZE + 1);
   localparam int AW = $clog2(GRID_SIZE);
   localparam int EW = (CW > COORD_WIDTH) ? CW : COORD_WIDTH;
   localparam int PW = 2 * CW;
   localparam int SW = ((PW > AREA_WIDTH) ? PW : AREA_WIDTH) + 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CLEAR = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_MARK  = 3'd3;
   localparam logic [2:0] S_MUL   = 3'd4;
   localparam logic [2:0] S_ADD   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   function automatic logic [CW-1:0] clip(input logic [COORD_WIDTH-1:0] v);
      logic [EW-1:0] ext;
      ext = EW'(v);
      if (ext > EW'(GRID_SIZE)) begin
         clip = CW'(GRID_SIZE);
      end else begin
         clip = CW'(ext);
      end
   endfunction

   logic [2:0]            state_ff, state_in;
   logic [CW-1:0]         x_ff, x_in;
   logic [CW-1:0]         x0_ff, x0_in;
   logic [CW-1:0]         x1_ff, x1_in;
   logic [CW-1:0]         h_ff, h_in;
   logic [GRID_SIZE-1:0]  mask_ff, mask_in;
   logic                  rd_pend_ff, rd_pend_in;
   logic [AW-1:0]         rd_x_ff, rd_x_in;
   logic [PW-1:0]         prod_ff, prod_in;
   logic [AREA_WIDTH-1:0] area_ff, area_in;
   logic                  acc_ff, acc_in;
   logic                  clear_rsp_ff, clear_rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  req_take;
   logic [CW-1:0]         lx, by, rx, ty;
   logic                  issue;
   logic                  hit;
   logic [SW-1:0]         sum;
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [GRID_SIZE-1:0]  mem_wdata;
   logic [GRID_SIZE-1:0]  mem_rdata;

   roa_row_mem #(
      .DEPTH(GRID_SIZE),
      .WIDTH(GRID_SIZE),
      .ADDR_WIDTH(AW)
   ) u_row_mem (
      .clock(clock),
      .wr_en(mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_addr(x_ff[AW-1:0]),
      .rd_data(mem_rdata)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign lx = clip(req_payload.left_x);
   assign by = clip(req_payload.bottom_y);
   assign rx = clip(req_payload.right_x);
   assign ty = clip(req_payload.top_y);

   assign issue = (x_ff < x1_ff);
   assign hit = |(mem_rdata & mask_ff);
   assign sum = SW'(area_ff) + SW'(prod_ff);

   always_comb begin
      for (int i = 0; i < GRID_SIZE; i++) begin
         mask_in[i] = (CW'(i) >= by) && (CW'(i) < ty);
      end
   end

   always_comb begin
      state_in = state_ff;
      x_in = x_ff;
      x0_in = x0_ff;
      x1_in = x1_ff;
      h_in = h_ff;
      rd_pend_in = 1'b0;
      rd_x_in = x_ff[AW-1:0];
      prod_in = prod_ff;
      area_in = area_ff;
      acc_in = acc_ff;
      clear_rsp_in = clear_rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      mem_we = 1'b0;
      mem_waddr = x_ff[AW-1:0];
      mem_wdata = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (!req_payload.kind) begin
                  state_in = S_CLEAR;
                  x_in = '0;
                  area_in = '0;
                  clear_rsp_in = 1'b1;
               end else if (rx <= lx || ty <= by) begin
                  state_in = S_DONE;
                  acc_in = 1'b1;
               end else begin
                  state_in = S_CHECK;
                  x_in = lx;
                  x0_in = lx;
                  x1_in = rx;
                  h_in = ty - by;
               end
            end
         end
         S_CLEAR: begin
            mem_we = 1'b1;
            x_in = x_ff + 1'b1;
            if (x_ff == CW'(GRID_SIZE - 1)) begin
               acc_in = 1'b1;
               state_in = clear_rsp_ff ? S_DONE : S_IDLE;
               clear_rsp_in = 1'b0;
            end
         end
         S_CHECK: begin
            if (issue) begin
               x_in = x_ff + 1'b1;
            end
            if (rd_pend_ff && hit) begin
               state_in = S_DONE;
               acc_in = 1'b0;
            end else begin
               rd_pend_in = issue;
               if (!issue && !rd_pend_ff) begin
                  state_in = S_MARK;
                  x_in = x0_ff;
               end
            end
         end
         S_MARK: begin
            if (issue) begin
               x_in = x_ff + 1'b1;
            end
            rd_pend_in = issue;
            mem_we = rd_pend_ff;
            mem_waddr = rd_x_ff;
            mem_wdata = mem_rdata | mask_ff;
            if (!issue && !rd_pend_ff) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in = PW'(x1_ff - x0_ff) * PW'(h_ff);
            state_in = S_ADD;
         end
         S_ADD: begin
            if (sum > SW'(AREA_MAX)) begin
               area_in = AREA_MAX;
            end else begin
               area_in = AREA_WIDTH'(sum);
            end
            acc_in = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in.accepted = acc_ff;
               rsp_in.total_area = area_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         x_ff <= '0;
         rd_pend_ff <= 1'b0;
         area_ff <= '0;
         clear_rsp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         x_ff <= x_in;
         rd_pend_ff <= rd_pend_in;
         area_ff <= area_in;
         clear_rsp_ff <= clear_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff <= x0_in;
      x1_ff <= x1_in;
      h_ff <= h_in;
      rd_x_ff <= rd_x_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      rsp_ff <= rsp_in;
      if (req_take) begin
         mask_ff <= mask_in;
      end
   end

   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff != S_IDLE))
      else $error("request transfer did not start work");

   a_mark_rows_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MARK && rd_pend_ff) |-> !hit)
      else $error("marking a row that overlaps occupied cells");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_CLEAR || state_ff == S_MARK))
      else $error("bitmap written outside clear or mark");

   a_reject_keeps_area: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !acc_ff) |-> $stable(area_ff))
      else $error("rejected rectangle changed the area");

endmodule
